[rtl/core/nirfd_pkg.sv]
`timescale 1ns / 1ps

package nirfd_pkg;

    localparam int unsigned TICK_W      = 16;
    localparam int unsigned FRAME_BITS  = 32;
    localparam int unsigned COUNT_W     = $clog2(FRAME_BITS);
    localparam int unsigned BYTE_W      = 8;
    localparam int unsigned KIND_W      = 2;
    localparam int unsigned CFG_IDX_W   = 3;
    localparam int unsigned QUEUE_DEPTH = 2;
    localparam int unsigned QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int unsigned QLVL_W      = $clog2(QUEUE_DEPTH + 1);

    localparam logic [CFG_IDX_W-1:0] CFG_START  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_REPEAT = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ZERO   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_ONE    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_TOL    = 3'd4;

    localparam logic [TICK_W-1:0] START_RST  = 16'd12442;
    localparam logic [TICK_W-1:0] REPEAT_RST = 16'd10368;
    localparam logic [TICK_W-1:0] ZERO_RST   = 16'd1032;
    localparam logic [TICK_W-1:0] ONE_RST    = 16'd2074;
    localparam logic [TICK_W-1:0] TOL_RST    = 16'd500;

    localparam logic [KIND_W-1:0] EV_NONE   = 2'd0;
    localparam logic [KIND_W-1:0] EV_FRAME  = 2'd1;
    localparam logic [KIND_W-1:0] EV_REPEAT = 2'd2;

    typedef struct packed {
        logic start_hit;
        logic repeat_hit;
        logic zero_hit;
        logic one_hit;
    } nirfd_class_t;

    function automatic logic in_window(
        input logic [TICK_W-1:0] t,
        input logic [TICK_W-1:0] nominal,
        input logic [TICK_W-1:0] tol
    );
        logic [TICK_W-1:0] d;
        d = (t >= nominal) ? (t - nominal) : (nominal - t);
        return d < tol;
    endfunction

endpackage

[rtl/core/nirfd_front.sv]
`timescale 1ns / 1ps

module nirfd_front (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_we,
    input  logic [nirfd_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [nirfd_pkg::TICK_W-1:0]        cfg_data,
    input  logic [nirfd_pkg::TICK_W-1:0]        interval_ticks,
    output nirfd_pkg::nirfd_class_t             cls
);

    logic [nirfd_pkg::TICK_W-1:0] start_reg;
    logic [nirfd_pkg::TICK_W-1:0] repeat_reg;
    logic [nirfd_pkg::TICK_W-1:0] zero_reg;
    logic [nirfd_pkg::TICK_W-1:0] one_reg;
    logic [nirfd_pkg::TICK_W-1:0] tol_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_reg  <= nirfd_pkg::START_RST;
            repeat_reg <= nirfd_pkg::REPEAT_RST;
            zero_reg   <= nirfd_pkg::ZERO_RST;
            one_reg    <= nirfd_pkg::ONE_RST;
            tol_reg    <= nirfd_pkg::TOL_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                nirfd_pkg::CFG_START:  start_reg  <= cfg_data;
                nirfd_pkg::CFG_REPEAT: repeat_reg <= cfg_data;
                nirfd_pkg::CFG_ZERO:   zero_reg   <= cfg_data;
                nirfd_pkg::CFG_ONE:    one_reg    <= cfg_data;
                nirfd_pkg::CFG_TOL:    tol_reg    <= cfg_data;
                default:
                begin
                end
            endcase
        end
    end

    // window compares are independent of decoder state
    always_comb
    begin
        cls.start_hit  = nirfd_pkg::in_window(interval_ticks, start_reg, tol_reg);
        cls.repeat_hit = nirfd_pkg::in_window(interval_ticks, repeat_reg, tol_reg);
        cls.zero_hit   = nirfd_pkg::in_window(interval_ticks, zero_reg, tol_reg);
        cls.one_hit    = nirfd_pkg::in_window(interval_ticks, one_reg, tol_reg);
    end

endmodule

[rtl/core/nirfd_queue.sv]
`timescale 1ns / 1ps

module nirfd_queue (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             push,
    input  nirfd_pkg::nirfd_class_t          push_cls,
    output logic                             full,
    input  logic                             pop,
    output logic                             head_valid,
    output nirfd_pkg::nirfd_class_t          head_cls,
    output logic [nirfd_pkg::QLVL_W-1:0]     level
);

    localparam logic [nirfd_pkg::QPTR_W-1:0] LAST_PTR =
        nirfd_pkg::QPTR_W'(nirfd_pkg::QUEUE_DEPTH - 1);
    localparam logic [nirfd_pkg::QLVL_W-1:0] FULL_LVL =
        nirfd_pkg::QLVL_W'(nirfd_pkg::QUEUE_DEPTH);

    nirfd_pkg::nirfd_class_t mem [nirfd_pkg::QUEUE_DEPTH];

    logic [nirfd_pkg::QPTR_W-1:0] wr_ptr_reg;
    logic [nirfd_pkg::QPTR_W-1:0] wr_ptr_next;
    logic [nirfd_pkg::QPTR_W-1:0] rd_ptr_reg;
    logic [nirfd_pkg::QPTR_W-1:0] rd_ptr_next;
    logic [nirfd_pkg::QLVL_W-1:0] level_reg;
    logic [nirfd_pkg::QLVL_W-1:0] level_next;
    logic                         do_push;
    logic                         do_pop;

    assign full       = (level_reg == FULL_LVL);
    assign head_valid = (level_reg != '0);
    assign head_cls   = mem[rd_ptr_reg];
    assign level      = level_reg;
    assign do_push    = push && !full;
    assign do_pop     = pop && head_valid;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        level_next  = level_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            level_next = level_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            level_next = level_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            level_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            level_reg  <= level_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem[wr_ptr_reg] <= push_cls;
        end
    end

endmodule

[rtl/core/nirfd_engine.sv]
`timescale 1ns / 1ps

module nirfd_engine (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                head_valid,
    input  nirfd_pkg::nirfd_class_t             head_cls,
    output logic                                pop,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic [nirfd_pkg::KIND_W-1:0]        event_kind,
    output logic [nirfd_pkg::BYTE_W-1:0]        address_byte,
    output logic [nirfd_pkg::BYTE_W-1:0]        command_byte
);

    typedef enum logic [1:0] {
        PH_IDLE  = 2'd0,
        PH_AWAIT = 2'd1,
        PH_DATA  = 2'd2
    } phase_t;

    localparam logic [nirfd_pkg::COUNT_W-1:0] LAST_BIT =
        nirfd_pkg::COUNT_W'(nirfd_pkg::FRAME_BITS - 1);

    phase_t                               phase_reg;
    phase_t                               phase_next;
    logic [nirfd_pkg::COUNT_W-1:0]        count_reg;
    logic [nirfd_pkg::COUNT_W-1:0]        count_next;
    logic [nirfd_pkg::FRAME_BITS-1:0]     shift_reg;
    logic [nirfd_pkg::FRAME_BITS-1:0]     shift_next;
    logic [nirfd_pkg::BYTE_W-1:0]         held_addr_reg;
    logic [nirfd_pkg::BYTE_W-1:0]         held_addr_next;
    logic [nirfd_pkg::BYTE_W-1:0]         held_cmd_reg;
    logic [nirfd_pkg::BYTE_W-1:0]         held_cmd_next;
    logic                                 out_valid_reg;
    logic                                 out_valid_next;
    logic [nirfd_pkg::KIND_W-1:0]         kind_reg;
    logic [nirfd_pkg::KIND_W-1:0]         kind_next;
    logic [nirfd_pkg::BYTE_W-1:0]         addr_out_reg;
    logic [nirfd_pkg::BYTE_W-1:0]         addr_out_next;
    logic [nirfd_pkg::BYTE_W-1:0]         cmd_out_reg;
    logic [nirfd_pkg::BYTE_W-1:0]         cmd_out_next;
    logic [nirfd_pkg::KIND_W-1:0]         kind;
    logic                                 check_ok;

    assign pop          = head_valid && (!out_valid_reg || out_ready);
    assign out_valid    = out_valid_reg;
    assign event_kind   = kind_reg;
    assign address_byte = addr_out_reg;
    assign command_byte = cmd_out_reg;

    always_comb
    begin
        phase_next     = phase_reg;
        count_next     = count_reg;
        shift_next     = shift_reg;
        held_addr_next = held_addr_reg;
        held_cmd_next  = held_cmd_reg;
        out_valid_next = out_valid_reg;
        kind_next      = kind_reg;
        addr_out_next  = addr_out_reg;
        cmd_out_next   = cmd_out_reg;
        kind           = nirfd_pkg::EV_NONE;
        check_ok       = 1'b0;
        if (pop)
        begin
            unique case (phase_reg)
                PH_AWAIT:
                begin
                    if (head_cls.start_hit)
                    begin
                        phase_next = PH_DATA;
                        count_next = '0;
                    end
                    else if (head_cls.repeat_hit)
                    begin
                        kind       = nirfd_pkg::EV_REPEAT;
                        phase_next = PH_IDLE;
                    end
                end
                PH_DATA:
                begin
                    if (head_cls.zero_hit || head_cls.one_hit)
                    begin
                        // lsb first: first bit ends up in bit 0
                        shift_next = {!head_cls.zero_hit,
                                      shift_reg[nirfd_pkg::FRAME_BITS-1:1]};
                        if (count_reg == LAST_BIT)
                        begin
                            check_ok = (shift_next[7:0] == ~shift_next[15:8]) &&
                                       (shift_next[23:16] == ~shift_next[31:24]);
                            if (check_ok)
                            begin
                                held_addr_next = shift_next[7:0];
                                held_cmd_next  = shift_next[23:16];
                                kind           = nirfd_pkg::EV_FRAME;
                            end
                            phase_next = PH_IDLE;
                            count_next = '0;
                        end
                        else
                        begin
                            count_next = count_reg + 1'b1;
                        end
                    end
                    else
                    begin
                        phase_next = PH_AWAIT;
                        count_next = '0;
                    end
                end
                default:
                begin
                    phase_next = PH_AWAIT;
                    count_next = '0;
                end
            endcase
            out_valid_next = 1'b1;
            kind_next      = kind;
            addr_out_next  = held_addr_next;
            cmd_out_next   = held_cmd_next;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_IDLE;
            count_reg     <= '0;
            shift_reg     <= '0;
            held_addr_reg <= '0;
            held_cmd_reg  <= '0;
            out_valid_reg <= 1'b0;
            kind_reg      <= nirfd_pkg::EV_NONE;
            addr_out_reg  <= '0;
            cmd_out_reg   <= '0;
        end
        else
        begin
            phase_reg     <= phase_next;
            count_reg     <= count_next;
            shift_reg     <= shift_next;
            held_addr_reg <= held_addr_next;
            held_cmd_reg  <= held_cmd_next;
            out_valid_reg <= out_valid_next;
            kind_reg      <= kind_next;
            addr_out_reg  <= addr_out_next;
            cmd_out_reg   <= cmd_out_next;
        end
    end

endmodule

[rtl/core/nec_ir_frame_decoder_top.sv]
`timescale 1ns / 1ps

// nec ir frame decoder
// input channel (in_valid/in_ready): one item per falling edge of the
//   demodulated ir signal, carrying interval_ticks since the previous edge
// output channel (out_valid/out_ready): one item per input item with
//   event_kind (0 nothing, 1 frame, 2 repeat) and the held address and command
// config port: cfg_we with cfg_index 0..4 = start, repeat, zero, one and
//   tolerance ticks; write only while no item is in flight
// path: an accepted item is written into the queue, and the engine pops it into
//   the output register when that register is empty or being taken
// throughput: one item per cycle while out_ready stays high, set by the window
//   compares in the front and the state update in the back
// a two-entry queue sits between front and back; when the receiver stalls
//   the output register holds, the queue fills and in_ready drops once it
//   is full
// reset: all window registers take their nominal values, the decoder waits
//   for a first edge and the held address and command read zero

module nec_ir_frame_decoder_top (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_we,
    input  logic [nirfd_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [nirfd_pkg::TICK_W-1:0]        cfg_data,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic [nirfd_pkg::TICK_W-1:0]        interval_ticks,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic [nirfd_pkg::KIND_W-1:0]        event_kind,
    output logic [nirfd_pkg::BYTE_W-1:0]        address_byte,
    output logic [nirfd_pkg::BYTE_W-1:0]        command_byte
);

    nirfd_pkg::nirfd_class_t          front_cls;
    nirfd_pkg::nirfd_class_t          head_cls;
    logic                             q_full;
    logic                             head_valid;
    logic                             pop;
    logic [nirfd_pkg::QLVL_W-1:0]     q_level;

    assign in_ready = !q_full;

    nirfd_front u_front (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_we         (cfg_we),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .interval_ticks (interval_ticks),
        .cls            (front_cls)
    );

    nirfd_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (in_valid),
        .push_cls   (front_cls),
        .full       (q_full),
        .pop        (pop),
        .head_valid (head_valid),
        .head_cls   (head_cls),
        .level      (q_level)
    );

    nirfd_engine u_engine (
        .clk          (clk),
        .rst_n        (rst_n),
        .head_valid   (head_valid),
        .head_cls     (head_cls),
        .pop          (pop),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .event_kind   (event_kind),
        .address_byte (address_byte),
        .command_byte (command_byte)
    );

    a_level_bound: assert property (@(posedge clk) disable iff (!rst_n)
        q_level <= nirfd_pkg::QLVL_W'(nirfd_pkg::QUEUE_DEPTH))
        else $error("queue level beyond depth");

    a_pop_needs_item: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> q_level != '0)
        else $error("pop from empty queue");

    a_two_cycle_latency: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready && q_level == '0 && !out_valid) |-> ##2 out_valid)
        else $error("item did not reach output in two cycles");

    a_level_tracks: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready && !pop) |=> q_level == $past(q_level) + 1'b1)
        else $error("queue level did not follow a lone push");

endmodule
